// File: rtl/core/tvb_pkg.sv
// Shared types, constants and helpers for the transformed vertex bounds block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package tvb_pkg;

	localparam int COORD_W = 32;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 12;
	localparam int PROD_W  = 2 * COORD_W;
	// Three Q32.32 products plus the scaled offset need 65 bits; keep one spare.
	localparam int SUM_W   = PROD_W + 2;
	localparam int FRAC_W  = 16;
	localparam int SHR_W   = SUM_W - FRAC_W;

	localparam int MAX_SET_VERTICES = 4096;
	localparam int POS_CAP_I = (MAX_SET_VERTICES - 1 > (1 << IDX_W) - 1) ?
		(1 << IDX_W) - 1 : MAX_SET_VERTICES - 1;
	localparam logic [IDX_W-1:0] POS_CAP = IDX_W'(POS_CAP_I);

	typedef enum logic [2:0] {
		REG_X_COEF_XY       = 3'd0,
		REG_X_COEF_Z_OFS    = 3'd1,
		REG_Y_COEF_XY       = 3'd2,
		REG_Y_COEF_Z_OFS    = 3'd3,
		REG_DEPTH_COEF_XY   = 3'd4,
		REG_DEPTH_COEF_Z_OFS = 3'd5
	} cfg_reg_t;

	// Load strobes for the transform pipeline stages.
	typedef struct packed {
		logic load_s2;
		logic load_s3;
		logic load_s4;
	} tvb_adv_t;

	// Clamp a floor-shifted sum to the signed 32-bit range.
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SHR_W-1:0] v);
		logic upper_same;
		upper_same = (&v[SHR_W-1:COORD_W-1]) | ~(|v[SHR_W-1:COORD_W-1]);
		if (upper_same) begin
			sat_coord = v[COORD_W-1:0];
		end else if (v[SHR_W-1]) begin
			sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

// File: rtl/core/tvb_xform.sv
// One output column of the affine transform: multiply, sum, floor and saturate.
// Depends on tvb_pkg; three instances sit in transformed_vertex_bounds.
`timescale 1ns / 1ps

module tvb_xform import tvb_pkg::*; (
	input  logic                       clk,
	input  tvb_adv_t                   adv,
	input  logic signed [COORD_W-1:0]  x_s1,
	input  logic signed [COORD_W-1:0]  y_s1,
	input  logic signed [COORD_W-1:0]  z_s1,
	input  logic        [CFG_W-1:0]    coef_xy,
	input  logic        [CFG_W-1:0]    coef_z_ofs,
	output logic signed [COORD_W-1:0]  result_s4
);

	logic signed [COORD_W-1:0] cx, cy, cz, ofs;
	logic signed [PROD_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [SUM_W-1:0]   sum_s3;
	logic signed [SUM_W-1:0]   ofs_ext;

	assign cx  = coef_xy[COORD_W-1:0];
	assign cy  = coef_xy[CFG_W-1:COORD_W];
	assign cz  = coef_z_ofs[COORD_W-1:0];
	assign ofs = coef_z_ofs[CFG_W-1:COORD_W];
	assign ofs_ext = {{(SUM_W-COORD_W-FRAC_W){ofs[COORD_W-1]}}, ofs, {FRAC_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv.load_s2) begin
			px_s2 <= cx * x_s1;
			py_s2 <= cy * y_s1;
			pz_s2 <= cz * z_s1;
		end
		// Offset folded in at Q32.32 so one floor shift covers the whole sum.
		if (adv.load_s3) begin
			sum_s3 <= SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2) + ofs_ext;
		end
		if (adv.load_s4) begin
			result_s4 <= sat_coord(sum_s3[SUM_W-1:FRAC_W]);
		end
	end

endmodule

// File: rtl/core/tvb_bounds.sv
// Running box, lowest depth tracker and the result register.
// Depends on tvb_pkg; instantiated by transformed_vertex_bounds.
`timescale 1ns / 1ps

module tvb_bounds import tvb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic                       first,
	input  logic                       last,
	input  logic signed [COORD_W-1:0]  tx,
	input  logic signed [COORD_W-1:0]  ty,
	input  logic signed [COORD_W-1:0]  td,
	input  logic                       res_ready,
	output logic                       res_valid,
	output logic signed [COORD_W-1:0]  res_min_x,
	output logic signed [COORD_W-1:0]  res_max_x,
	output logic signed [COORD_W-1:0]  res_min_y,
	output logic signed [COORD_W-1:0]  res_max_y,
	output logic signed [COORD_W-1:0]  res_depth,
	output logic        [IDX_W-1:0]    res_index
);

	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q, min_d_q;
	logic        [IDX_W-1:0]   best_q, pos_q;
	logic signed [COORD_W-1:0] min_x_d, max_x_d, min_y_d, max_y_d, min_d_d;
	logic        [IDX_W-1:0]   best_d, pos, pos_d;
	logic                      res_valid_q;

	always_comb begin
		if (first) begin
			pos     = '0;
			min_x_d = tx;
			max_x_d = tx;
			min_y_d = ty;
			max_y_d = ty;
			min_d_d = td;
			best_d  = '0;
		end else begin
			pos     = pos_q;
			min_x_d = (tx < min_x_q) ? tx : min_x_q;
			max_x_d = (tx > max_x_q) ? tx : max_x_q;
			min_y_d = (ty < min_y_q) ? ty : min_y_q;
			max_y_d = (ty > max_y_q) ? ty : max_y_q;
			// Strict compare: on a tie the earlier vertex stays.
			min_d_d = (td < min_d_q) ? td : min_d_q;
			best_d  = (td < min_d_q) ? pos : best_q;
		end
		pos_d = (pos < POS_CAP) ? IDX_W'(pos + 1'b1) : POS_CAP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
			min_d_q     <= '0;
			best_q      <= '0;
			pos_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				min_x_q <= min_x_d;
				max_x_q <= max_x_d;
				min_y_q <= min_y_d;
				max_y_q <= max_y_d;
				min_d_q <= min_d_d;
				best_q  <= best_d;
				pos_q   <= pos_d;
			end
			if (take && last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			res_min_x <= min_x_d;
			res_max_x <= max_x_d;
			res_min_y <= min_y_d;
			res_max_y <= max_y_d;
			res_depth <= min_d_d;
			res_index <= best_d;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// File: rtl/core/transformed_vertex_bounds.sv
// Top level of the transformed vertex bounds block: config registers, input stage,
// stage control, three transform columns and the bounds tracker.
// Depends on tvb_pkg, tvb_xform and tvb_bounds.
`timescale 1ns / 1ps

// Each vertex (signed Q16.16 x, y, z) is transformed by the 3x4 affine matrix held in
// six 64-bit registers, floored to Q16.16 and saturated; the running box of x and y,
// the lowest depth and the set position of the first vertex reaching it are kept per
// set, and a vertex with last_of_set delivers one result. The block takes one vertex
// every cycle; after its last vertex is taken, a result passes the input register,
// multiply, sum and saturate stages, then the bounds update into the result register.
// Input stalls only when a finished result is not taken, the next last-of-set vertex
// waits in the final stage behind it, and the three stages ahead of that one are full.
// Write the configuration only while no vertex is in flight; cfg_ready is always high
// and writes to index 6 or 7 are dropped.
module transformed_vertex_bounds import tvb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [2:0]          cfg_index,
	input  logic        [CFG_W-1:0]    cfg_data,
	// vertex request channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_W-1:0]  vertex_x,
	input  logic signed [COORD_W-1:0]  vertex_y,
	input  logic signed [COORD_W-1:0]  vertex_z,
	input  logic                       first_of_set,
	input  logic                       last_of_set,
	// result request channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  box_min_x,
	output logic signed [COORD_W-1:0]  box_max_x,
	output logic signed [COORD_W-1:0]  box_min_y,
	output logic signed [COORD_W-1:0]  box_max_y,
	output logic signed [COORD_W-1:0]  lowest_depth,
	output logic        [IDX_W-1:0]    lowest_vertex_index
);

	logic [CFG_W-1:0] x_xy_q, x_zo_q, y_xy_q, y_zo_q, d_xy_q, d_zo_q;

	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	logic first_s1, first_s2, first_s3, first_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic adv1, adv2, adv3, adv4, take;
	tvb_adv_t adv;
	logic signed [COORD_W-1:0] tx_s4, ty_s4, td_s4;

	// Configuration: always ready, decode the index, drop unknown indexes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_xy_q <= '0;
			x_zo_q <= '0;
			y_xy_q <= '0;
			y_zo_q <= '0;
			d_xy_q <= '0;
			d_zo_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_COEF_XY:        x_xy_q <= cfg_data;
				REG_X_COEF_Z_OFS:     x_zo_q <= cfg_data;
				REG_Y_COEF_XY:        y_xy_q <= cfg_data;
				REG_Y_COEF_Z_OFS:     y_zo_q <= cfg_data;
				REG_DEPTH_COEF_XY:    d_xy_q <= cfg_data;
				REG_DEPTH_COEF_Z_OFS: d_zo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage control: each stage advances when the next one is empty or advancing.
	// The final stage only holds back a last-of-set vertex while the result
	// register is full and not being taken.
	assign adv4 = v_s4 && (!last_s4 || !out_valid || out_ready);
	assign adv3 = v_s3 && (!v_s4 || adv4);
	assign adv2 = v_s2 && (!v_s3 || adv3);
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign in_ready = !v_s1 || adv1;
	assign take = in_valid && in_ready;

	assign adv.load_s2 = adv1;
	assign adv.load_s3 = adv2;
	assign adv.load_s4 = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3) begin
				v_s4 <= 1'b1;
			end else if (adv4) begin
				v_s4 <= 1'b0;
			end
		end
	end

	// Hold the vertex and its flags alongside the transform stages.
	always_ff @(posedge clk) begin
		if (take) begin
			x_s1     <= vertex_x;
			y_s1     <= vertex_y;
			z_s1     <= vertex_z;
			first_s1 <= first_of_set;
			last_s1  <= last_of_set;
		end
		if (adv1) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
		if (adv2) begin
			first_s3 <= first_s2;
			last_s3  <= last_s2;
		end
		if (adv3) begin
			first_s4 <= first_s3;
			last_s4  <= last_s3;
		end
	end

	tvb_xform u_xform_x (
		.clk        (clk),
		.adv        (adv),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.z_s1       (z_s1),
		.coef_xy    (x_xy_q),
		.coef_z_ofs (x_zo_q),
		.result_s4  (tx_s4)
	);

	tvb_xform u_xform_y (
		.clk        (clk),
		.adv        (adv),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.z_s1       (z_s1),
		.coef_xy    (y_xy_q),
		.coef_z_ofs (y_zo_q),
		.result_s4  (ty_s4)
	);

	tvb_xform u_xform_d (
		.clk        (clk),
		.adv        (adv),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.z_s1       (z_s1),
		.coef_xy    (d_xy_q),
		.coef_z_ofs (d_zo_q),
		.result_s4  (td_s4)
	);

	// Merge the vertex into the running bounds as it leaves the final stage.
	tvb_bounds u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv4),
		.first     (first_s4),
		.last      (last_s4),
		.tx        (tx_s4),
		.ty        (ty_s4),
		.td        (td_s4),
		.res_ready (out_ready),
		.res_valid (out_valid),
		.res_min_x (box_min_x),
		.res_max_x (box_max_x),
		.res_min_y (box_min_y),
		.res_max_y (box_max_y),
		.res_depth (lowest_depth),
		.res_index (lowest_vertex_index)
	);

	// A new result only comes from a last-of-set vertex leaving the final stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(adv4 && last_s4))
		else $error("result raised without a last vertex leaving the final stage");

	// An empty final stage lets every earlier stage drain, so input stays open.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ready)
		else $error("input stalled while final stage is empty");

	// A blocked last vertex stays in the final stage until the result slot frees.
	a_blocked_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && last_s4 && out_valid && !out_ready) |=> (v_s4 && last_s4))
		else $error("blocked last vertex dropped from the final stage");

endmodule

// File: verif/transformed_vertex_bounds_tb.sv
// Self-checking testbench for transformed_vertex_bounds: directed and random vertex sets
// against a built-in affine transform and bounds predictor. Depends on tvb_pkg and the RTL.
`timescale 1ns / 1ps

module transformed_vertex_bounds_tb;
	import tvb_pkg::*;

	// Register indexes the block has no register behind; writes there must be dropped.
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	// Cycles to let an in-flight vertex with no result clear the four pipeline stages.
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_VERTICES = 1300;
	localparam int LONG_SET_LEN = 4100;

	// Q16.16 helpers for the directed matrices.
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_HALF = 32'h0000_8000;
	localparam logic [31:0] Q_MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MINV = 32'h8000_0000;

	// Wide accumulator: three exact Q32.32 products plus the scaled offset.
	localparam int ACC_W = 67;
	localparam logic signed [ACC_W-1:0] SAT_HI = 67'sd2147483647;
	localparam logic signed [ACC_W-1:0] SAT_LO = -67'sd2147483648;

	typedef struct {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] depth;
		logic        [IDX_W-1:0]   index;
	} box_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [2:0]                cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic signed [COORD_W-1:0] vertex_z;
	logic                      first_of_set;
	logic                      last_of_set;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] box_min_x;
	logic signed [COORD_W-1:0] box_max_x;
	logic signed [COORD_W-1:0] box_min_y;
	logic signed [COORD_W-1:0] box_max_y;
	logic signed [COORD_W-1:0] lowest_depth;
	logic        [IDX_W-1:0]   lowest_vertex_index;

	transformed_vertex_bounds u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.vertex_x            (vertex_x),
		.vertex_y            (vertex_y),
		.vertex_z            (vertex_z),
		.first_of_set        (first_of_set),
		.last_of_set         (last_of_set),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.box_min_x           (box_min_x),
		.box_max_x           (box_max_x),
		.box_min_y           (box_min_y),
		.box_max_y           (box_max_y),
		.lowest_depth        (lowest_depth),
		.lowest_vertex_index (lowest_vertex_index)
	);

	// Predictor state: the matrix as last written and the running bounds of the open set.
	logic [CFG_W-1:0]          matrix_regs [6];
	logic signed [COORD_W-1:0] track_min_x, track_max_x, track_min_y, track_max_y;
	logic signed [COORD_W-1:0] track_depth;
	logic [IDX_W-1:0]          track_index;
	logic [IDX_W-1:0]          next_position;

	box_t pending_boxes [$];

	// Idle controls: per-request random waits on each side, and a one-shot long hold-off.
	bit tx_idle;
	bit rx_idle;
	int hold_request;

	int mismatches;
	int vertices_sent;
	int boxes_checked;
	int matrices_loaded;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run of every test below.
	initial begin
		#5_000_000;
		$display("Timeout at %0t with %0d results outstanding", $time, pending_boxes.size());
		$display("transformed_vertex_bounds verification failed");
		$finish;
	end

	// One output column: coef_x*x + coef_y*y + coef_z*z + offset, floored to Q16.16 and
	// clamped to the signed 32-bit range. xy_reg holds {coef_y, coef_x}, zo_reg {offset, coef_z}.
	function automatic logic signed [COORD_W-1:0] affine_column(input logic [CFG_W-1:0] xy_reg,
			input logic [CFG_W-1:0] zo_reg, input logic signed [COORD_W-1:0] vx,
			input logic signed [COORD_W-1:0] vy, input logic signed [COORD_W-1:0] vz);
		logic signed [COORD_W-1:0] cx, cy, cz, ofs;
		logic signed [ACC_W-1:0]   wcx, wcy, wcz, wofs, wx, wy, wz, acc, floored;
		cx = xy_reg[31:0];
		cy = xy_reg[63:32];
		cz = zo_reg[31:0];
		ofs = zo_reg[63:32];
		wcx = cx;
		wcy = cy;
		wcz = cz;
		wofs = ofs;
		wx = vx;
		wy = vy;
		wz = vz;
		acc = wcx * wx + wcy * wy + wcz * wz + (wofs <<< FRAC_W);
		floored = acc >>> FRAC_W;
		if (floored > SAT_HI)
			return Q_MAXV;
		if (floored < SAT_LO)
			return Q_MINV;
		return floored[COORD_W-1:0];
	endfunction

	// Fold one accepted vertex into the running bounds; queue a box on the last of a set.
	function automatic void track_vertex(input logic signed [COORD_W-1:0] vx,
			input logic signed [COORD_W-1:0] vy, input logic signed [COORD_W-1:0] vz,
			input logic first, input logic last);
		logic signed [COORD_W-1:0] tx, ty, td;
		logic [IDX_W-1:0]          pos;
		box_t                      box;
		tx = affine_column(matrix_regs[REG_X_COEF_XY], matrix_regs[REG_X_COEF_Z_OFS], vx, vy, vz);
		ty = affine_column(matrix_regs[REG_Y_COEF_XY], matrix_regs[REG_Y_COEF_Z_OFS], vx, vy, vz);
		td = affine_column(matrix_regs[REG_DEPTH_COEF_XY], matrix_regs[REG_DEPTH_COEF_Z_OFS],
			vx, vy, vz);
		if (first) begin
			pos = '0;
			track_min_x = tx;
			track_max_x = tx;
			track_min_y = ty;
			track_max_y = ty;
			track_depth = td;
			track_index = '0;
		end else begin
			pos = next_position;
			if (tx < track_min_x) track_min_x = tx;
			if (tx > track_max_x) track_max_x = tx;
			if (ty < track_min_y) track_min_y = ty;
			if (ty > track_max_y) track_max_y = ty;
			// strict compare: on a tie the earlier vertex keeps the index
			if (td < track_depth) begin
				track_depth = td;
				track_index = pos;
			end
		end
		next_position = (pos < POS_CAP) ? pos + 1'b1 : POS_CAP;
		if (last) begin
			box.min_x = track_min_x;
			box.max_x = track_max_x;
			box.min_y = track_min_y;
			box.max_y = track_max_y;
			box.depth = track_depth;
			box.index = track_index;
			pending_boxes.push_back(box);
		end
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return Q_MAXV;
			1: return Q_MINV;
			2, 3, 4: return $urandom;
			default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_coef();
		case ($urandom_range(0, 11))
			0: return Q_MAXV;
			1: return Q_MINV;
			2: return '0;
			3: return Q_ONE;
			4, 5: return $urandom;
			// half the draws: modest gains within +-4.0 so the box stays unsaturated
			default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		endcase
	endfunction

	task automatic compare_field(input string label, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			mismatches++;
		end
	endtask

	// Result side: draw a random stall per result, honor a requested long hold-off, and
	// check every accepted result against the oldest predicted box.
	initial begin : result_monitor
		int   stall_left;
		int   hold_left;
		box_t want;
		stall_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_boxes.size() == 0) begin
					$display("%0t: result with nothing expected, actual min_x %h max_x %h",
						$time, box_min_x, box_max_x);
					mismatches++;
				end else begin
					want = pending_boxes.pop_front();
					compare_field("box_min_x", want.min_x, box_min_x);
					compare_field("box_max_x", want.max_x, box_max_x);
					compare_field("box_min_y", want.min_y, box_min_y);
					compare_field("box_max_y", want.max_y, box_max_y);
					compare_field("lowest_depth", want.depth, lowest_depth);
					compare_field("lowest_vertex_index", 32'(want.index),
						32'(lowest_vertex_index));
				end
				boxes_checked++;
				stall_left = rx_idle ? $urandom_range(0, 5) : 0;
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			// one assignment of out_ready per edge, whichever branch wins
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one vertex request after a random gap and hold it until the block takes it.
	task automatic send_vertex(input logic signed [COORD_W-1:0] vx,
			input logic signed [COORD_W-1:0] vy, input logic signed [COORD_W-1:0] vz,
			input logic first, input logic last);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= vx;
		vertex_y <= vy;
		vertex_z <= vz;
		first_of_set <= first;
		last_of_set <= last;
		do @(posedge clk); while (!in_ready);
		track_vertex(vx, vy, vz, first, last);
		vertices_sent++;
	endtask

	// A set of random vertices; ragged sets scatter the flags to break the framing.
	task automatic send_set(input int len, input bit ragged);
		logic first, last;
		for (int i = 0; i < len; i++) begin
			first = (i == 0);
			last = (i == len - 1);
			if (ragged) begin
				first = ($urandom_range(0, 7) == 0);
				last = ($urandom_range(0, 3) == 0);
			end
			send_vertex(rand_coord(), rand_coord(), rand_coord(), first, last);
		end
	endtask

	// Drop the input, let every predicted result arrive, then clear the pipeline.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_DEPTH_COEF_Z_OFS)
			matrix_regs[idx] = value;
	endtask

	// Write all six matrix registers back to back; optionally poke the unused indexes.
	task automatic load_matrix(input logic [CFG_W-1:0] x_xy, input logic [CFG_W-1:0] x_zo,
			input logic [CFG_W-1:0] y_xy, input logic [CFG_W-1:0] y_zo,
			input logic [CFG_W-1:0] d_xy, input logic [CFG_W-1:0] d_zo, input bit poke_spare);
		write_reg(REG_X_COEF_XY, x_xy);
		write_reg(REG_X_COEF_Z_OFS, x_zo);
		write_reg(REG_Y_COEF_XY, y_xy);
		write_reg(REG_Y_COEF_Z_OFS, y_zo);
		write_reg(REG_DEPTH_COEF_XY, d_xy);
		write_reg(REG_DEPTH_COEF_Z_OFS, d_zo);
		if (poke_spare) begin
			write_reg(REG_SPARE_6, {$urandom, $urandom});
			write_reg(REG_SPARE_7, {$urandom, $urandom});
		end
		cfg_valid <= 1'b0;
		matrices_loaded++;
	endtask

	task automatic load_identity();
		load_matrix({32'h0, Q_ONE}, 64'h0, {Q_ONE, 32'h0}, 64'h0, 64'h0, {32'h0, Q_ONE}, 1'b0);
	endtask

	task automatic load_random_matrix();
		load_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
			{rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
			{rand_coef(), rand_coef()}, {rand_coef(), rand_coef()}, $urandom_range(0, 1));
	endtask

	// Corner behavior with hand-picked vertices and matrices.
	task automatic test_directed();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// a vertex ahead of any first merges into the all-zero reset bounds
		load_identity();
		send_vertex(32'sd100, -32'sd200, 32'sd300, 1'b0, 1'b1);
		// one-vertex sets at the coordinate extremes
		send_vertex(Q_MAXV, Q_MINV, Q_MAXV, 1'b1, 1'b1);
		send_vertex(Q_MINV, Q_MAXV, Q_MINV, 1'b1, 1'b1);
		// equal depths: the earlier vertex keeps the index
		send_vertex(32'sd10, 32'sd10, 32'sd5, 1'b1, 1'b0);
		send_vertex(32'sd20, -32'sd10, 32'sd3, 1'b0, 1'b0);
		send_vertex(-32'sd20, 32'sd30, 32'sd3, 1'b0, 1'b1);
		// no implicit restart after a last: bounds and position carry on
		send_vertex(32'sd50, 32'sd0, 32'sd1, 1'b0, 1'b1);
		wait_idle();
		// half-LSB products: floor sends +0.5 LSB to 0 and -0.5 LSB to -1
		load_matrix({32'h0, Q_HALF}, 64'h0, {Q_HALF, 32'h0}, 64'h0, 64'h0, {32'h0, Q_HALF}, 1'b1);
		send_vertex(32'sd1, -32'sd1, 32'sd1, 1'b1, 1'b1);
		send_vertex(-32'sd1, 32'sd1, -32'sd1, 1'b1, 1'b1);
		send_vertex(32'sd3, -32'sd3, -32'sd3, 1'b1, 1'b1);
		wait_idle();
		// largest gains and offsets: drive every column into both saturation limits
		load_matrix({Q_MAXV, Q_MAXV}, {Q_MAXV, Q_MAXV}, {Q_MINV, Q_MINV}, {Q_MINV, Q_MINV},
			{Q_MAXV, Q_MINV}, {Q_MINV, Q_MAXV}, 1'b1);
		send_vertex(Q_MAXV, Q_MAXV, Q_MAXV, 1'b1, 1'b0);
		send_vertex(Q_MINV, Q_MINV, Q_MINV, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1);
		send_vertex(Q_MINV, Q_MAXV, Q_MINV, 1'b1, 1'b1);
		wait_idle();
		// all-ones registers: every coefficient and offset at -1 LSB
		load_matrix('1, '1, '1, '1, '1, '1, 1'b1);
		send_vertex(Q_MAXV, Q_MINV, 32'sd65536, 1'b1, 1'b0);
		send_vertex(32'sd1, 32'sd1, 32'sd1, 1'b0, 1'b1);
		wait_idle();
	endtask

	// One set longer than the index range: the position sticks at its cap.
	task automatic test_long_set();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		load_identity();
		// depth falls on every vertex, so the best index follows the capped position
		for (int i = 0; i < LONG_SET_LEN; i++)
			send_vertex(32'(i), -32'(i), 32'sd1000000 - 32'(i), i == 0, i == LONG_SET_LEN - 1);
		// and once more with the deepest vertex early in the set
		for (int i = 0; i < 300; i++)
			send_vertex(rand_coord(), rand_coord(), (i == 7) ? Q_MINV : 32'(i), i == 0,
				i == 299);
		wait_idle();
	endtask

	// Hold the result side for a long stretch while single-vertex sets keep coming, so the
	// pipeline fills and the input stalls; then pause until every result is back.
	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		load_random_matrix();
		hold_request = 80;
		for (int i = 0; i < 30; i++)
			send_set(1, 1'b0);
		wait_idle();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int i = 0; i < 5; i++)
			send_set($urandom_range(1, 6), 1'b0);
		// full pause with nothing in flight, then carry on
		wait_idle();
		for (int i = 0; i < 5; i++)
			send_set($urandom_range(1, 6), 1'b0);
		wait_idle();
	endtask

	// Mostly well-framed sets of random length and content under fresh matrices, with a
	// share of ragged framing; idling switches between phases.
	task automatic test_random();
		int start_count;
		int len;
		start_count = vertices_sent;
		while (vertices_sent - start_count < RANDOM_VERTICES) begin
			load_random_matrix();
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			for (int s = 0; s < 12; s++) begin
				case ($urandom_range(0, 19))
					0: len = $urandom_range(41, 120);
					1, 2, 3: len = $urandom_range(9, 40);
					default: len = $urandom_range(1, 8);
				endcase
				send_set(len, $urandom_range(0, 9) == 0);
			end
			wait_idle();
		end
	endtask

	initial begin
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		vertex_x <= '0;
		vertex_y <= '0;
		vertex_z <= '0;
		first_of_set <= 1'b0;
		last_of_set <= 1'b0;
		out_ready <= 1'b0;
		arst_n <= 1'b0;
		for (int k = 0; k < 6; k++)
			matrix_regs[k] = '0;
		track_min_x = '0;
		track_max_x = '0;
		track_min_y = '0;
		track_max_y = '0;
		track_depth = '0;
		track_index = '0;
		next_position = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_request = 0;
		mismatches = 0;
		vertices_sent = 0;
		boxes_checked = 0;
		matrices_loaded = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_long_set();
		test_backpressure();
		test_random();

		// all stimulus is in; wait_idle at the end of each test already drained the results
		wait_idle();
		$display("Sent %0d vertices under %0d matrices and checked %0d bounding boxes,",
			vertices_sent, matrices_loaded, boxes_checked);
		$display("including saturation, floor rounding, depth ties and a capped long set.");
		if (mismatches == 0 && pending_boxes.size() == 0) begin
			$display("transformed_vertex_bounds verification clean");
		end else begin
			$display("transformed_vertex_bounds verification failed");
		end
		$finish;
	end

endmodule
